>>> design/ccr_pkg.sv
package ccr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int BNC_W         = 16;
    localparam int BNC_FRAC      = 12;
    localparam int SQRT_STEPS    = 32;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_TRIGGER  = 2'd1,
        EV_RESOLVED = 2'd2
    } ccr_event_t;

    // Per-request data carried alongside the arithmetic
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        rsum;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic [31:0]        cdist;
        logic               negx;
        logic               negy;
        logic               trig;
        logic               body;
        logic               hit;
    } ccr_side_t;

    typedef struct packed {
        ccr_event_t  event_res;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
    } ccr_result_t;

endpackage

>>> design/ccr_front.sv
module ccr_front
    import ccr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [31:0] pos_a_x,
    input  logic signed [31:0] pos_a_y,
    input  logic signed [31:0] pos_b_x,
    input  logic signed [31:0] pos_b_y,
    input  logic [30:0]        radius_a,
    input  logic [30:0]        radius_b,
    input  logic               trigger_a,
    input  logic               trigger_b,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic               has_body,
    output logic               valid_out,
    output ccr_side_t          side_out,
    output logic [63:0]        sq_out
);

    logic               v1_reg, v2_reg, v3_reg;
    ccr_side_t          side1_reg, side1_next;
    ccr_side_t          side2_reg, side2_next;
    ccr_side_t          side3_reg, side3_next;
    logic signed [32:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic [63:0]        qx2_reg, qx2_next, qy2_reg, qy2_next, rsq2_reg, rsq2_next;
    logic [63:0]        sq3_reg, sq3_next;

    always_comb
    begin
        logic [31:0] mxv;
        logic [31:0] myv;
        logic [64:0] sum;

        // difference of centres and radius sum
        dx1_next = {pos_a_x[31], pos_a_x} - {pos_b_x[31], pos_b_x};
        dy1_next = {pos_a_y[31], pos_a_y} - {pos_b_y[31], pos_b_y};
        side1_next      = '0;
        side1_next.ax   = pos_a_x;
        side1_next.ay   = pos_a_y;
        side1_next.vx   = vel_x;
        side1_next.vy   = vel_y;
        side1_next.rsum = 32'(radius_a) + 32'(radius_b);
        side1_next.trig = trigger_a | trigger_b;
        side1_next.body = has_body;

        // magnitudes and squares
        mxv = dx1_reg[32] ? 32'(-dx1_reg) : dx1_reg[31:0];
        myv = dy1_reg[32] ? 32'(-dy1_reg) : dy1_reg[31:0];
        side2_next      = side1_reg;
        side2_next.mx   = mxv;
        side2_next.my   = myv;
        side2_next.negx = dx1_reg[32];
        side2_next.negy = dy1_reg[32];
        qx2_next  = 64'(mxv) * 64'(mxv);
        qy2_next  = 64'(myv) * 64'(myv);
        rsq2_next = 64'(side1_reg.rsum) * 64'(side1_reg.rsum);

        // overlap test; a carry out of the square sum never overlaps
        sum            = {1'b0, qx2_reg} + {1'b0, qy2_reg};
        side3_next     = side2_reg;
        side3_next.hit = !sum[64] && (sum[63:0] < rsq2_reg);
        sq3_next       = sum[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side1_reg <= side1_next;
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            side2_reg <= side2_next;
            qx2_reg   <= qx2_next;
            qy2_reg   <= qy2_next;
            rsq2_reg  <= rsq2_next;
            side3_reg <= side3_next;
            sq3_reg   <= sq3_next;
        end
    end

    assign valid_out = v3_reg;
    assign side_out  = side3_reg;
    assign sq_out    = sq3_reg;

endmodule

>>> design/ccr_sqrt.sv
module ccr_sqrt
    import ccr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        valid_in,
    input  ccr_side_t   side_in,
    input  logic [63:0] sq_in,
    output logic        valid_out,
    output ccr_side_t   side_out
);

    localparam int LAST = SQRT_STEPS - 1;

    logic        v_reg     [SQRT_STEPS];
    logic        v_prev    [SQRT_STEPS];
    ccr_side_t   side_reg  [SQRT_STEPS];
    ccr_side_t   side_prev [SQRT_STEPS];
    logic [33:0] rem_reg   [SQRT_STEPS];
    logic [33:0] rem_prev  [SQRT_STEPS];
    logic [33:0] rem_next  [SQRT_STEPS];
    logic [31:0] root_reg  [SQRT_STEPS];
    logic [31:0] root_prev [SQRT_STEPS];
    logic [31:0] root_next [SQRT_STEPS];
    logic [63:0] sb_reg    [SQRT_STEPS];
    logic [63:0] sb_prev   [SQRT_STEPS];
    logic [63:0] sb_next   [SQRT_STEPS];

    assign v_prev[0]    = valid_in;
    assign side_prev[0] = side_in;
    assign rem_prev[0]  = '0;
    assign root_prev[0] = '0;
    assign sb_prev[0]   = sq_in;

    for (genvar k = 1; k < SQRT_STEPS; k++)
    begin : g_link
        assign v_prev[k]    = v_reg[k-1];
        assign side_prev[k] = side_reg[k-1];
        assign rem_prev[k]  = rem_reg[k-1];
        assign root_prev[k] = root_reg[k-1];
        assign sb_prev[k]   = sb_reg[k-1];
    end

    // one root bit per stage: bring down two radicand bits, try 4r+1
    always_comb
    begin
        logic [35:0] trem;
        logic [35:0] trial;
        logic        ge;

        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            trem         = {rem_prev[k], sb_prev[k][63:62]};
            trial        = {2'b00, root_prev[k], 2'b01};
            ge           = (trem >= trial);
            rem_next[k]  = ge ? 34'(trem - trial) : trem[33:0];
            root_next[k] = {root_prev[k][30:0], ge};
            sb_next[k]   = {sb_prev[k][61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                v_reg[k] <= v_prev[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                side_reg[k] <= side_prev[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                sb_reg[k]   <= sb_next[k];
            end
        end
    end

    always_comb
    begin
        side_out       = side_reg[LAST];
        side_out.cdist = root_reg[LAST];
    end

    assign valid_out = v_reg[LAST];

endmodule

>>> design/ccr_div.sv
module ccr_div
    import ccr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 valid_in,
    input  ccr_side_t            side_in,
    output logic                 valid_out,
    output ccr_side_t            side_out,
    output logic [FRAC_BITS:0]   ux_mag,
    output logic [FRAC_BITS:0]   uy_mag
);

    localparam int Q_W   = FRAC_BITS + 1;
    localparam int STEPS = Q_W;
    localparam int NUM_W = 32 + Q_W;
    localparam int LAST  = STEPS - 1;

    logic             v_reg     [STEPS];
    logic             v_prev    [STEPS];
    ccr_side_t        side_reg  [STEPS];
    ccr_side_t        side_prev [STEPS];
    logic [31:0]      rem_reg   [STEPS][2];
    logic [31:0]      rem_prev  [STEPS][2];
    logic [31:0]      rem_next  [STEPS][2];
    logic [Q_W-1:0]   q_reg     [STEPS][2];
    logic [Q_W-1:0]   q_prev    [STEPS][2];
    logic [Q_W-1:0]   q_next    [STEPS][2];
    logic [Q_W-1:0]   lo_reg    [STEPS][2];
    logic [Q_W-1:0]   lo_prev   [STEPS][2];
    logic [Q_W-1:0]   lo_next   [STEPS][2];
    logic [NUM_W-1:0] num_x, num_y;

    // numerator |d| * 2^F + dist/2, rounds the quotient to nearest
    assign num_x = NUM_W'({side_in.mx, {FRAC_BITS{1'b0}}}) + NUM_W'(side_in.cdist >> 1);
    assign num_y = NUM_W'({side_in.my, {FRAC_BITS{1'b0}}}) + NUM_W'(side_in.cdist >> 1);

    assign v_prev[0]     = valid_in;
    assign side_prev[0]  = side_in;
    assign rem_prev[0][0] = num_x[NUM_W-1:Q_W];
    assign rem_prev[0][1] = num_y[NUM_W-1:Q_W];
    assign lo_prev[0][0]  = num_x[Q_W-1:0];
    assign lo_prev[0][1]  = num_y[Q_W-1:0];
    assign q_prev[0][0]   = '0;
    assign q_prev[0][1]   = '0;

    for (genvar k = 1; k < STEPS; k++)
    begin : g_link
        assign v_prev[k]    = v_reg[k-1];
        assign side_prev[k] = side_reg[k-1];
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            assign rem_prev[k][l] = rem_reg[k-1][l];
            assign q_prev[k][l]   = q_reg[k-1][l];
            assign lo_prev[k][l]  = lo_reg[k-1][l];
        end
    end

    // restoring division, one quotient bit per stage and lane
    always_comb
    begin
        logic [32:0] t;
        logic [32:0] dv;
        logic        ge;

        for (int k = 0; k < STEPS; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv             = {1'b0, side_prev[k].cdist};
                t              = {rem_prev[k][l], lo_prev[k][l][Q_W-1]};
                ge             = (t >= dv);
                rem_next[k][l] = ge ? 32'(t - dv) : t[31:0];
                q_next[k][l]   = {q_prev[k][l][Q_W-2:0], ge};
                lo_next[k][l]  = {lo_prev[k][l][Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                v_reg[k] <= v_prev[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                side_reg[k] <= side_prev[k];
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[k][l] <= rem_next[k][l];
                    q_reg[k][l]   <= q_next[k][l];
                    lo_reg[k][l]  <= lo_next[k][l];
                end
            end
        end
    end

    assign valid_out = v_reg[LAST];
    assign side_out  = side_reg[LAST];
    assign ux_mag    = q_reg[LAST][0];
    assign uy_mag    = q_reg[LAST][1];

endmodule

>>> design/ccr_back.sv
module ccr_back
    import ccr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  ccr_side_t          side_in,
    input  logic [FRAC_BITS:0] ux_mag,
    input  logic [FRAC_BITS:0] uy_mag,
    input  logic [BNC_W-1:0]   bnc,
    input  logic               out_ready,
    output logic               adv,
    output logic               out_valid,
    output ccr_result_t        res
);

    localparam int Q_W    = FRAC_BITS + 1;
    localparam int M_W    = 33;
    localparam int PV_W   = 32 + Q_W + 1;
    localparam int VS_W   = PV_W + 1;
    localparam int VS_W1  = VS_W + 1;
    localparam int PXM_W  = Q_W + 33;
    localparam int PXM_W1 = PXM_W + 1;
    localparam int OFF_W  = 35;
    localparam int PX_W   = 37;
    localparam int C_W    = 33;
    localparam int NX_W   = 33;
    localparam int N2P_W  = NX_W + BNC_W;
    localparam int N2P_W1 = N2P_W + 1;
    localparam int N2_W   = N2P_W1 - BNC_FRAC;
    localparam int TOT_W  = N2_W + 1;
    localparam int NV_W   = TOT_W + 1;

    localparam logic [PXM_W:0]  HALF_P = PXM_W1'(1) << (FRAC_BITS - 1);
    localparam logic [VS_W:0]   HALF_V = VS_W1'(1) << (FRAC_BITS - 1);
    localparam logic [N2P_W:0]  HALF_B = N2P_W1'(1) << (BNC_FRAC - 1);

    typedef struct packed {
        ccr_side_t                  side;
        logic                       zero;
        logic [1:0][Q_W-1:0]        um;
        logic                       cneg;
        logic [1:0]                 sgn;
        logic [1:0][PX_W-1:0]       px;
    } bk_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    bk_t  bk1_reg, bk1_next, bk2_reg, bk3_reg, bk3_next, bk4_reg, bk4_next;
    bk_t  bk5_reg, bk5_next, bk6_reg, bk7_reg, bk8_reg;

    logic [M_W-1:0]          m1_reg, m1_next;
    logic signed [PV_W-1:0]  pv1_reg [2];
    logic signed [PV_W-1:0]  pv1_next [2];
    logic [PXM_W-1:0]        pxm2_reg [2];
    logic [PXM_W-1:0]        pxm2_next [2];
    logic signed [VS_W-1:0]  vs2_reg, vs2_next;
    logic [OFF_W-1:0]        off3_reg [2];
    logic [OFF_W-1:0]        off3_next [2];
    logic [VS_W-1:0]         vsm3_reg, vsm3_next;
    logic [C_W-1:0]          c4_reg, c4_next;
    logic [PXM_W-1:0]        nxp5_reg [2];
    logic [PXM_W-1:0]        nxp5_next [2];
    logic [NX_W-1:0]         nx6_reg [2];
    logic [NX_W-1:0]         nx6_next [2];
    logic [NX_W-1:0]         nx7_reg [2];
    logic [N2P_W-1:0]        n2p7_reg [2];
    logic [N2P_W-1:0]        n2p7_next [2];
    logic [TOT_W-1:0]        tot8_reg [2];
    logic [TOT_W-1:0]        tot8_next [2];
    logic                    out_valid_reg;
    ccr_result_t             res_reg, res_next;

    function automatic logic [31:0] sat32(input logic signed [NV_W-1:0] x);
        logic [31:0] r;
        if ((&x[NV_W-1:31]) || !(|x[NV_W-1:31]))
        begin
            r = x[31:0];
        end
        else
        begin
            r = x[NV_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // the pipeline moves unless the last stage is full and the result port is blocked
    assign adv = !v8_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        logic signed [Q_W:0]      us;
        logic                     neg;
        logic signed [31:0]       pa;
        logic signed [31:0]       vl;
        logic signed [NV_W-1:0]   nv [2];
        logic signed [NV_W-1:0]   pxs [2];
        logic                     push;

        // stage 1: signed direction, push distance, velocity products
        bk1_next      = '0;
        bk1_next.side = side_in;
        bk1_next.zero = (side_in.cdist == '0);
        bk1_next.um[0] = ux_mag;
        bk1_next.um[1] = uy_mag;
        m1_next = M_W'(side_in.rsum) - M_W'(side_in.cdist) + (M_W'(1) << FRAC_BITS);
        for (int l = 0; l < 2; l++)
        begin
            neg = (l == 0) ? side_in.negx : side_in.negy;
            vl  = (l == 0) ? side_in.vx : side_in.vy;
            us  = neg ? -$signed({1'b0, bk1_next.um[l]}) : $signed({1'b0, bk1_next.um[l]});
            pv1_next[l] = vl * us;
        end

        // stage 2: push products, dot product sum
        for (int l = 0; l < 2; l++)
        begin
            pxm2_next[l] = PXM_W'(bk1_reg.um[l]) * PXM_W'(m1_reg);
        end
        vs2_next = VS_W'(pv1_reg[0]) + VS_W'(pv1_reg[1]);

        // stage 3: round push offsets, magnitude of the dot product
        bk3_next      = bk2_reg;
        bk3_next.cneg = vs2_reg[VS_W-1];
        for (int l = 0; l < 2; l++)
        begin
            off3_next[l] = OFF_W'(({1'b0, pxm2_reg[l]} + HALF_P) >> FRAC_BITS);
        end
        vsm3_next = vs2_reg[VS_W-1] ? VS_W'(-vs2_reg) : VS_W'(vs2_reg);

        // stage 4: pushed position, rounded normal speed
        bk4_next = bk3_reg;
        for (int l = 0; l < 2; l++)
        begin
            neg = (l == 0) ? bk3_reg.side.negx : bk3_reg.side.negy;
            pa  = (l == 0) ? bk3_reg.side.ax : bk3_reg.side.ay;
            bk4_next.px[l] = neg ? PX_W'(pa) - PX_W'(off3_reg[l])
                                 : PX_W'(pa) + PX_W'(off3_reg[l]);
        end
        c4_next = C_W'(({1'b0, vsm3_reg} + HALF_V) >> FRAC_BITS);

        // stage 5: normal velocity products
        bk5_next = bk4_reg;
        for (int l = 0; l < 2; l++)
        begin
            neg = (l == 0) ? bk4_reg.side.negx : bk4_reg.side.negy;
            bk5_next.sgn[l] = neg ^ bk4_reg.cneg;
            nxp5_next[l]    = PXM_W'(bk4_reg.um[l]) * PXM_W'(c4_reg);
        end

        // stage 6: round normal velocity
        for (int l = 0; l < 2; l++)
        begin
            nx6_next[l] = NX_W'(({1'b0, nxp5_reg[l]} + HALF_P) >> FRAC_BITS);
        end

        // stage 7: scale by bounciness
        for (int l = 0; l < 2; l++)
        begin
            n2p7_next[l] = N2P_W'(nx6_reg[l]) * N2P_W'(bnc);
        end

        // stage 8: total normal correction magnitude
        for (int l = 0; l < 2; l++)
        begin
            tot8_next[l] = TOT_W'(nx7_reg[l])
                         + TOT_W'(N2_W'(({1'b0, n2p7_reg[l]} + HALF_B) >> BNC_FRAC));
        end

        // result: choose between echo and resolved values
        for (int l = 0; l < 2; l++)
        begin
            vl     = (l == 0) ? bk8_reg.side.vx : bk8_reg.side.vy;
            nv[l]  = bk8_reg.sgn[l] ? NV_W'(vl) + NV_W'(tot8_reg[l])
                                    : NV_W'(vl) - NV_W'(tot8_reg[l]);
            pxs[l] = NV_W'($signed(bk8_reg.px[l]));
        end
        push = bk8_reg.side.hit && !bk8_reg.side.trig && !bk8_reg.zero;
        if (!bk8_reg.side.hit)
        begin
            res_next.event_res = EV_NONE;
        end
        else if (bk8_reg.side.trig)
        begin
            res_next.event_res = EV_TRIGGER;
        end
        else
        begin
            res_next.event_res = EV_RESOLVED;
        end
        res_next.pos_x = push ? sat32(pxs[0]) : bk8_reg.side.ax;
        res_next.pos_y = push ? sat32(pxs[1]) : bk8_reg.side.ay;
        res_next.vel_x = (push && bk8_reg.side.body) ? sat32(nv[0]) : bk8_reg.side.vx;
        res_next.vel_y = (push && bk8_reg.side.body) ? sat32(nv[1]) : bk8_reg.side.vy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg <= valid_in;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                v6_reg <= v5_reg;
                v7_reg <= v6_reg;
                v8_reg <= v7_reg;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= v8_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bk1_reg  <= bk1_next;
            m1_reg   <= m1_next;
            bk2_reg  <= bk1_reg;
            vs2_reg  <= vs2_next;
            bk3_reg  <= bk3_next;
            vsm3_reg <= vsm3_next;
            bk4_reg  <= bk4_next;
            c4_reg   <= c4_next;
            bk5_reg  <= bk5_next;
            bk6_reg  <= bk5_reg;
            bk7_reg  <= bk6_reg;
            bk8_reg  <= bk7_reg;
            for (int l = 0; l < 2; l++)
            begin
                pv1_reg[l]  <= pv1_next[l];
                pxm2_reg[l] <= pxm2_next[l];
                off3_reg[l] <= off3_next[l];
                nxp5_reg[l] <= nxp5_next[l];
                nx6_reg[l]  <= nx6_next[l];
                nx7_reg[l]  <= nx6_reg[l];
                n2p7_reg[l] <= n2p7_next[l];
                tot8_reg[l] <= tot8_next[l];
            end
        end
        if (!out_valid_reg || out_ready)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

>>> design/circle_collision_resolve.sv
// Circle-against-circle collision response in 2D, fixed point with FRAC_BITS
// fractional bits (Q16.16 by default). Each request carries both centres, both
// radii, trigger flags, body A's velocity and a has-body flag; each gives
// exactly one result: the event kind and A's new position and velocity. One
// request is taken per clock while in_ready is high; results leave in request
// order. The pipeline has three stages for the squared distance and overlap
// test, 32 stages of the integer square root (one root bit each),
// FRAC_BITS + 1 stages of the dual direction divider (one quotient bit each)
// and nine stages of push-out, velocity response and output register. While
// the result port is blocked the pipeline keeps taking requests until a
// result reaches its last stage. Bounciness (unsigned Q4.12, reset 0) is
// written through the cfg port, which is always ready; write it only while no
// request is in flight.
module circle_collision_resolve
    import ccr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] pos_a_x,
    input  logic signed [31:0] pos_a_y,
    input  logic signed [31:0] pos_b_x,
    input  logic signed [31:0] pos_b_y,
    input  logic [30:0]        radius_a,
    input  logic [30:0]        radius_b,
    input  logic               trigger_a,
    input  logic               trigger_b,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic               has_body,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         event_res,
    output logic signed [31:0] new_pos_x,
    output logic signed [31:0] new_pos_y,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BNC_W-1:0]   bounciness
);

    logic               adv;
    logic               f_valid, s_valid, d_valid;
    ccr_side_t          f_side, s_side, d_side;
    logic [63:0]        f_sq;
    logic [FRAC_BITS:0] ux_mag, uy_mag;
    logic [BNC_W-1:0]   bnc_reg;
    ccr_result_t        res;

    // bounciness register, read by the response stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnc_reg <= '0;
        end
        else if (cfg_valid)
        begin
            bnc_reg <= bounciness;
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = adv;

    // centre difference, squares and overlap test
    ccr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .pos_a_x   (pos_a_x),
        .pos_a_y   (pos_a_y),
        .pos_b_x   (pos_b_x),
        .pos_b_y   (pos_b_y),
        .radius_a  (radius_a),
        .radius_b  (radius_b),
        .trigger_a (trigger_a),
        .trigger_b (trigger_b),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .has_body  (has_body),
        .valid_out (f_valid),
        .side_out  (f_side),
        .sq_out    (f_sq)
    );

    // floor of the centre distance
    ccr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (f_valid),
        .side_in   (f_side),
        .sq_in     (f_sq),
        .valid_out (s_valid),
        .side_out  (s_side)
    );

    // unit direction magnitudes, rounded
    ccr_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (s_valid),
        .side_in   (s_side),
        .valid_out (d_valid),
        .side_out  (d_side),
        .ux_mag    (ux_mag),
        .uy_mag    (uy_mag)
    );

    // push-out, velocity response and result register
    ccr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (d_valid),
        .side_in   (d_side),
        .ux_mag    (ux_mag),
        .uy_mag    (uy_mag),
        .bnc       (bnc_reg),
        .out_ready (out_ready),
        .adv       (adv),
        .out_valid (out_valid),
        .res       (res)
    );

    assign event_res = res.event_res;
    assign new_pos_x = res.pos_x;
    assign new_pos_y = res.pos_y;
    assign new_vel_x = res.vel_x;
    assign new_vel_y = res.vel_y;

endmodule

>>> design/ccr_checker.sv
module ccr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_res,
    input logic [31:0] new_pos_x,
    input logic [31:0] new_pos_y,
    input logic [31:0] new_vel_x,
    input logic [31:0] new_vel_y
);

    // a blocked result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(new_pos_x) && $stable(new_pos_y)
            && $stable(new_vel_x) && $stable(new_vel_y))
        else $error("result changed while blocked");

    // back-pressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request port stalled without a blocked result");

    // nothing leaves straight out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present right after reset");

endmodule

bind circle_collision_resolve ccr_checker u_ccr_checker (.*);
